>>> design/srmb_pkg.sv
package srmb_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 16;

  // Field widths fixed by the interface.
  localparam int IN_VALUE_W = 16;
  localparam int MAX_W      = 16;
  localparam int REMOVED_W  = 16;
  localparam int COUNT_OUT_W = 6;

  // Width for comparing a stored value against max_value.
  localparam int CMP_W   = (VALUE_WIDTH > MAX_W) ? VALUE_WIDTH : MAX_W;
  // Live counter must hold CAPACITY itself.
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REPLACE = 1'b1;

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic en;     // update this cycle
    logic shift;  // drop the head and move everything one slot forward
    logic ins;    // insert value
    val_t value;
  } cell_cmd_t;

endpackage

>>> design/srmb_cell.sv
module srmb_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               is_first,
  input  srmb_pkg::cell_cmd_t cmd,
  input  srmb_pkg::val_t     left_val,
  input  srmb_pkg::val_t     right_val,
  output srmb_pkg::val_t     val_o
);
  import srmb_pkg::*;

  val_t val_r;
  val_t val_nxt;
  val_t cur;
  val_t prev;
  logic cur_le;
  logic prev_le;

  // A zero slot is empty and sorts behind every live value.
  always_comb begin
    cur     = cmd.shift ? right_val : val_r;
    prev    = cmd.shift ? val_r : left_val;
    cur_le  = (cur != '0) && (cur <= cmd.value);
    prev_le = is_first || ((prev != '0) && (prev <= cmd.value));
    if (!cmd.ins || cur_le) begin
      val_nxt = cur;
    end else if (prev_le) begin
      val_nxt = cmd.value;
    end else begin
      val_nxt = prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (cmd.en) begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule

>>> design/sorted_replace_min_buffer.sv
// The result of an item is registered and shown in the cycle after the beat that takes it.
// Throughput: one item per cycle; every cell of the sorted chain compares and
// shifts at once, so busy never rises and start may stay high.
// Results are strobed by out_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties every slot, clears the live count and
// sets max_value to 100.
module sorted_replace_min_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_value,
  output logic        out_valid,
  output logic [15:0] out_removed_value,
  output logic        out_removed_valid,
  output logic        out_dropped,
  output logic [5:0]  out_live_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import srmb_pkg::*;

  // Configuration register.
  logic [MAX_W-1:0] max_value_r;

  // Live count and the chain of slots.
  cnt_t count_r;
  cnt_t count_nxt;
  val_t slot [CAPACITY];

  cell_cmd_t cmd;
  val_t      v;
  logic      accept;
  logic      live;
  logic      full;
  logic      empty;
  logic      take;
  logic      drop;

  // Result registers.
  logic                 out_valid_r;
  logic [REMOVED_W-1:0] removed_value_r;
  logic                 removed_valid_r;
  logic                 dropped_r;
  logic [COUNT_OUT_W-1:0] live_count_r;

  // Every beat is taken as soon as it is presented, so the block never holds off start.
  assign busy   = 1'b0;
  assign accept = start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= MAX_W'(100);
    end else if (cfg_we) begin
      max_value_r <= cfg_wdata;
    end
  end

  // Classify the incoming beat. A zero or oversized value counts as an empty
  // slot and is never inserted; a load into a full buffer is discarded.
  always_comb begin
    v     = VALUE_WIDTH'(in_value);
    live  = (v != '0) && (CMP_W'(v) <= CMP_W'(max_value_r));
    full  = (count_r == cnt_t'(CAPACITY));
    empty = (count_r == '0);
    take  = (in_operation == OP_REPLACE) && !empty;
    drop  = (in_operation == OP_LOAD) && live && full;

    cmd.en    = accept;
    cmd.shift = take;
    cmd.ins   = live && ((in_operation == OP_REPLACE) || !full);
    cmd.value = v;

    count_nxt = count_r - cnt_t'(take) + cnt_t'(cmd.ins);
  end

  // The chain: each cell looks at its neighbors to decide whether it keeps its
  // value, takes the new one, or takes the one from behind or ahead of it.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      val_t left_val;
      val_t right_val;
      if (i == 0) begin : g_head
        assign left_val = '0;
      end else begin : g_mid_l
        assign left_val = slot[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign right_val = '0;
      end else begin : g_mid_r
        assign right_val = slot[i+1];
      end
      srmb_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_first  (i == 0),
        .cmd       (cmd),
        .left_val  (left_val),
        .right_val (right_val),
        .val_o     (slot[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // The head slot is zero when the buffer is empty, so it serves as the
  // removed value directly.
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value_r <= take ? REMOVED_W'(slot[0]) : '0;
      removed_valid_r <= take;
      dropped_r       <= drop;
      live_count_r    <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_value_r;
  assign out_removed_valid = removed_valid_r;
  assign out_dropped       = dropped_r;
  assign out_live_count    = live_count_r;

endmodule

>>> design/srmb_checker.sv
module srmb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_removed_value,
  input logic        out_removed_valid,
  input logic        out_dropped,
  input logic [5:0]  out_live_count
);

  // Each accepted beat gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted beat");

  // A removal and a drop never come from the same beat.
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> !out_removed_valid)
    else $error("dropped and removed in one result");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_removed_valid) |-> (out_removed_value == 16'd0))
    else $error("removed value nonzero without a removal");

  // A dropped load leaves the count unchanged.
  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid ##1 (out_valid && out_dropped)) |-> (out_live_count == $past(out_live_count)))
    else $error("live count moved on a dropped load");

endmodule

bind sorted_replace_min_buffer srmb_checker u_srmb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_removed_value (out_removed_value),
  .out_removed_valid (out_removed_valid),
  .out_dropped       (out_dropped),
  .out_live_count    (out_live_count)
);

>>> tb/sv/tb_sorted_replace_min_buffer.sv
`timescale 1ns / 1ps

module tb_sorted_replace_min_buffer;
  import srmb_pkg::*;

  // One result beat, field by field, in the order of the result ports.
  typedef struct packed {
    logic [REMOVED_W-1:0]   removed_value;
    logic                   removed_valid;
    logic                   dropped;
    logic [COUNT_OUT_W-1:0] live_count;
  } outcome_t;

  // A directed row is sent reps times. Rows whose outcome is obvious carry it
  // typed in; the rest are checked against the predictor.
  typedef struct {
    logic     op;
    val_t     value;
    int       reps;
    bit       typed;
    outcome_t want;
  } stim_row_t;

  // One random phase: the max_value setting, the share of cycles in which the
  // sender holds start low, the number of beats and the share of loads.
  typedef struct {
    logic [MAX_W-1:0] max_limit;
    int               idle_pct;
    int               beats;
    int               load_pct;
  } phase_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_operation;
  logic [IN_VALUE_W-1:0]  in_value;
  logic                   out_valid;
  logic [REMOVED_W-1:0]   out_removed_value;
  logic                   out_removed_valid;
  logic                   out_dropped;
  logic [COUNT_OUT_W-1:0] out_live_count;
  logic                   cfg_we;
  logic [MAX_W-1:0]       cfg_wdata;

  // Shadow copy of the buffer, kept by the predictor.
  val_t             shadow_store[CAPACITY];
  int               shadow_held;
  logic [MAX_W-1:0] shadow_max;

  outcome_t expected_outcomes[$];
  int       mismatch_count;

  // Set by the driver together with each beat it presents. When typed_beat is
  // high, typed_outcome replaces the predicted outcome in the queue.
  bit       typed_beat;
  outcome_t typed_outcome;

  sorted_replace_min_buffer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_removed_value (out_removed_value),
    .out_removed_valid (out_removed_valid),
    .out_dropped       (out_dropped),
    .out_live_count    (out_live_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Insert a live value behind every held value that is not greater than it,
  // so equal values keep their arrival order.
  function automatic void sort_in(val_t v);
    int pos;
    pos = shadow_held;
    while (pos > 0 && shadow_store[pos-1] > v) begin
      shadow_store[pos] = shadow_store[pos-1];
      pos--;
    end
    shadow_store[pos] = v;
    shadow_held++;
  endfunction

  // Apply one beat to the shadow buffer and return the result it must give.
  function automatic outcome_t insert_or_replace(logic op, val_t v);
    outcome_t res;
    bit       live;
    res  = '0;
    // Zero, or anything above max_value, is an empty slot and is never stored.
    live = (v != '0) && (v <= shadow_max);
    if (op == OP_REPLACE) begin
      if (shadow_held > 0) begin
        res.removed_value = shadow_store[0];
        res.removed_valid = 1'b1;
        for (int k = 1; k < shadow_held; k++) shadow_store[k-1] = shadow_store[k];
        shadow_store[shadow_held-1] = '0;
        shadow_held--;
      end
      // The removal frees a slot, so a replace on a full buffer always fits.
      if (live) sort_in(v);
    end else if (live) begin
      if (shadow_held >= CAPACITY) res.dropped = 1'b1;
      else sort_in(v);
    end
    res.live_count = shadow_held[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Every accepted beat is predicted in the same process that checks results,
  // and before the check, so the order holds whatever the result latency is.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (start && !busy) begin
        want = insert_or_replace(in_operation, in_value);
        if (typed_beat) want = typed_outcome;
        expected_outcomes.push_back(want);
      end
      if (out_valid) begin
        got = {out_removed_value, out_removed_valid, out_dropped, out_live_count};
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, live_count",
                          got.live_count, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.removed_value !== want.removed_value)
            report_mismatch("removed_value", got.removed_value, want.removed_value);
          if (got.removed_valid !== want.removed_valid)
            report_mismatch("removed_valid", got.removed_valid, want.removed_valid);
          if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
          if (got.live_count !== want.live_count)
            report_mismatch("live_count", got.live_count, want.live_count);
        end
      end
    end
  end

  // Present one beat from a falling edge and hold it until the block takes it.
  // Before the beat, start is held low for a random number of cycles.
  task automatic send_beat(input logic op, input val_t v, input int idle_pct,
                           input bit typed, input outcome_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_value      <= v;
    typed_beat    = typed;
    typed_outcome = want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stop sending, wait until every result is back, then give the registered
  // result path some slack.
  task automatic drain_results;
    start      <= 1'b0;
    typed_beat = 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Only called while nothing is in flight, so the shadow copy can follow at once.
  task automatic write_max(input logic [MAX_W-1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we     <= 1'b0;
    shadow_max = m;
  endtask

  // Values for the random part: mostly live ones, many of them drawn from a
  // narrow range so that equal values meet, plus zeros, values above the limit
  // and raw 16-bit patterns.
  function automatic val_t pick_value(logic [MAX_W-1:0] lim);
    int roll;
    int top;
    roll = $urandom_range(99);
    top  = (lim < 8) ? lim : 8;
    if (roll < 6) return '0;
    if (roll < 14 || lim == '0) return val_t'($urandom_range(16'hFFFF));
    if (roll < 20) begin
      if (lim == 16'hFFFF) return val_t'($urandom_range(16'hFFFF));
      return val_t'($urandom_range(16'hFFFF, lim + 1));
    end
    if (roll < 45) return val_t'($urandom_range(top, 1));
    return val_t'($urandom_range(lim, 1));
  endfunction

  initial begin
    stim_row_t directed_rows[] = '{
      // Replace on an empty buffer: nothing removed, the new value still goes in.
      '{OP_REPLACE, 16'd5,     1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd1}},
      // Empty incoming values: zero, just above the limit, all ones.
      '{OP_LOAD,    16'd0,     1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd1}},
      '{OP_LOAD,    16'd101,   1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd1}},
      '{OP_LOAD,    16'hFFFF,  1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd1}},
      // The limit itself is live; then a new minimum and an equal value.
      '{OP_LOAD,    16'd100,   1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd2}},
      '{OP_LOAD,    16'd1,     1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd3}},
      '{OP_LOAD,    16'd5,     1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd4}},
      '{OP_REPLACE, 16'd0,     1,  1'b1, '{16'd1,  1'b1, 1'b0, 6'd3}},
      '{OP_REPLACE, 16'd100,   1,  1'b1, '{16'd5,  1'b1, 1'b0, 6'd3}},
      // Fill the buffer to capacity with one repeated value.
      '{OP_LOAD,    16'd42,    29, 1'b0, '0},
      // Load when full drops a live value but never an empty one.
      '{OP_LOAD,    16'd42,    1,  1'b1, '{16'd0,  1'b0, 1'b1, 6'd32}},
      '{OP_LOAD,    16'd0,     1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd32}},
      '{OP_LOAD,    16'd200,   1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd32}},
      // Replace when full always fits.
      '{OP_REPLACE, 16'd3,     1,  1'b1, '{16'd5,  1'b1, 1'b0, 6'd32}},
      '{OP_REPLACE, 16'd0,     1,  1'b1, '{16'd3,  1'b1, 1'b0, 6'd31}},
      '{OP_REPLACE, 16'h8000,  1,  1'b1, '{16'd42, 1'b1, 1'b0, 6'd30}},
      // Drain to empty, then replace on the empty buffer once more.
      '{OP_REPLACE, 16'd0,     30, 1'b0, '0},
      '{OP_REPLACE, 16'd0,     1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd0}},
      '{OP_REPLACE, 16'h7FFF,  1,  1'b1, '{16'd0,  1'b0, 1'b0, 6'd0}},
      '{OP_LOAD,    16'd99,    1,  1'b0, '0}
    };
    phase_t plan[7] = '{
      '{16'd100,   0,  300, 70},  // reset limit, fills the buffer and drops
      '{16'hFFFF,  86, 250, 55},  // widest limit, sparse beats
      '{16'd0,     0,  40,  50},  // a limit of zero makes every value empty
      '{16'd1,     33, 150, 60},  // only the value one is live: all equal
      '{16'd1000,  86, 250, 40},  // drain-leaning mix
      '{16'd0,     33, 250, 65},  // limit drawn at random below
      '{16'hFFFF,  0,  200, 35}
    };
    logic op;

    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_LOAD;
    in_value       = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    typed_beat     = 1'b0;
    typed_outcome  = '0;
    mismatch_count = 0;
    foreach (shadow_store[k]) shadow_store[k] = '0;
    shadow_held = 0;
    shadow_max  = 16'd100;
    plan[5].max_limit = MAX_W'($urandom_range(65534, 2));

    // Synchronous reset, held low from the start and released once.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, back to back, at the reset value of max_value.
    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++) begin
        send_beat(directed_rows[r].op, directed_rows[r].value, 0,
                  directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random phases. The limit is only rewritten once every result is back.
    foreach (plan[p]) begin
      drain_results();
      write_max(plan[p].max_limit);
      for (int n = 0; n < plan[p].beats; n++) begin
        op = ($urandom_range(99) < plan[p].load_pct) ? OP_LOAD : OP_REPLACE;
        send_beat(op, pick_value(plan[p].max_limit), plan[p].idle_pct, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("sorted_replace_min_buffer: match");
    end else begin
      $display("sorted_replace_min_buffer: mismatch");
    end
    $finish;
  end

  // A correct run finishes well before this timeout, even with the sparse phases.
  initial begin
    #5000000;
    $display("sorted_replace_min_buffer: mismatch");
    $finish;
  end

endmodule

>>> sorted_replace_min_buffer.f
design/srmb_pkg.sv
design/srmb_cell.sv
design/sorted_replace_min_buffer.sv
design/srmb_checker.sv
tb/sv/tb_sorted_replace_min_buffer.sv
